// File: hdl/prufer_code_converter_top_assert.svh
// assertion helpers for the prufer code converter top level
`ifndef PRUFER_CODE_CONVERTER_TOP_ASSERT_SVH
`define PRUFER_CODE_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pcc_pkg.sv
package pcc_pkg;

    // field and register widths
    localparam int NODE_W    = 13;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int MIN_NODES = 3;

    localparam logic [NODE_W-1:0] NCOUNT_RESET = NODE_W'(MIN_NODES);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

    // one request
    typedef struct packed {
        logic              operation;
        logic [NODE_W-1:0] node_value;
        logic [IDX_W-1:0]  read_index;
    } t_item;

    // one result
    typedef struct packed {
        logic [NODE_W-1:0] result_value;
        logic              result_valid;
    } t_result;

    // datapath commands, one per controller step
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLR_CNT,
        CMD_LOAD,
        CMD_LOAD_WR,
        CMD_READ,
        CMD_CLR_RES,
        CMD_FIND_RD,
        CMD_FIND_CK,
        CMD_LEAF,
        CMD_DEC,
        CMD_CHAIN,
        CMD_FINISH
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic clr_cnt_last;
        logic clr_res_last;
        logic load_last;
        logic p_ge_n;
        logic cnt_nz;
        logic chain;
        logic i1_le_l;
    } t_status;

endpackage

// File: hdl/prufer_code_converter_top.sv
// Prufer code converter: turns a labelled tree on n nodes (root is node n)
// from its parent array into its Prufer code (direction 0) or back (1).
// Registers: index 0 direction, index 1 node count, written with i_cfg_we;
// each write starts a new job and clears the child counts with busy high.
// Requests: start is taken when busy is low. operation 0 loads the next
// element (parent of nodes 1..n-1, or code elements 1..n-2); operation 1
// reads back result element read_index. A load after a finished job starts
// a new job. The last load of a job also runs the conversion: a result
// clear, a leaf pointer walk that updates the child count store for each
// emitted element, and a count clear. For a read, o_strobe is high for one
// cycle with o_result, result_valid low and result_value zero when no job
// is done or the index is outside the result. The receiver cannot stall;
// results are never held. Reset (synchronous, active low) sets direction 0
// and node count 3, then clears the child count store with busy high.
`include "prufer_code_converter_top_assert.svh"

module prufer_code_converter_top #(
    parameter int MAX_NODES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  pcc_pkg::t_item                i_item,
    output logic                          busy,
    output logic                          o_strobe,
    output pcc_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcc_pkg::CFG_W-1:0]     i_cfg_data
);
    import pcc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    pcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_read   (i_item.operation),
        .i_cfg_we (i_cfg_we),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // stores, counters and pointers
    pcc_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_result)
    );

    // a result only follows an accepted read request
    `PCC_ASSERT_IMPL(a_strobe_after_read, i_clk, i_rst_n, o_strobe, $past(start && !busy && i_item.operation && !i_cfg_we), "result strobe without a read request")
    // an accepted load request holds off the next one
    `PCC_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, start && !busy && !i_item.operation, busy, "not busy after a load request")
    // results are single-cycle strobes
    `PCC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "result strobe longer than one cycle")

endmodule

// File: hdl/pcc_ctrl.sv
module pcc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_read,
    input  logic             i_cfg_we,
    input  pcc_pkg::t_status i_status,
    output pcc_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_strobe
);
    import pcc_pkg::*;

    typedef enum logic [3:0] {
        S_CLR_CNT,
        S_IDLE,
        S_LOAD_WR,
        S_READ_OUT,
        S_CLR_RES,
        S_FIND_RD,
        S_FIND_CK,
        S_LEAF,
        S_DEC,
        S_CHAIN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_strobe;

    // next state and command for the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_CLR_CNT: begin
                o_cmd = CMD_CLR_CNT;
                if (i_status.clr_cnt_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_read) begin
                        o_cmd   = CMD_READ;
                        n_state = S_READ_OUT;
                    end else begin
                        o_cmd   = CMD_LOAD;
                        n_state = S_LOAD_WR;
                    end
                end
            end
            S_LOAD_WR: begin
                o_cmd   = CMD_LOAD_WR;
                n_state = i_status.load_last ? S_CLR_RES : S_IDLE;
            end
            S_READ_OUT: begin
                n_state = S_IDLE;
            end
            S_CLR_RES: begin
                o_cmd = CMD_CLR_RES;
                if (i_status.clr_res_last) n_state = S_FIND_RD;
            end
            S_FIND_RD: begin
                o_cmd   = CMD_FIND_RD;
                n_state = i_status.p_ge_n ? S_FINISH : S_FIND_CK;
            end
            S_FIND_CK: begin
                o_cmd   = CMD_FIND_CK;
                n_state = i_status.cnt_nz ? S_FIND_RD : S_LEAF;
            end
            S_LEAF: begin
                o_cmd   = CMD_LEAF;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd = CMD_DEC;
                if (i_status.chain) n_state = S_CHAIN;
                else if (i_status.i1_le_l) n_state = S_FIND_RD;
                else n_state = S_FINISH;
            end
            S_CHAIN: begin
                o_cmd   = CMD_CHAIN;
                n_state = i_status.i1_le_l ? S_DEC : S_FINISH;
            end
            S_FINISH: begin
                o_cmd   = CMD_FINISH;
                n_state = S_CLR_CNT;
            end
            default: begin
                n_state = S_CLR_CNT;
            end
        endcase
        // a register write restarts the count clear
        if (i_cfg_we) n_state = S_CLR_CNT;
    end

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR_CNT;
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state != S_IDLE);
            r_strobe <= (n_state == S_READ_OUT);
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

// File: hdl/pcc_datapath.sv
module pcc_datapath #(
    parameter int MAX_NODES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pcc_pkg::t_item                   i_item,
    input  logic                             i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcc_pkg::CFG_W-1:0]        i_cfg_data,
    input  pcc_pkg::t_cmd                    i_cmd,
    output pcc_pkg::t_status                 o_status,
    output pcc_pkg::t_result                 o_result
);
    import pcc_pkg::*;

    localparam int DEPTH = MAX_NODES + 2;
    localparam int NW    = $clog2(DEPTH);
    localparam int WW    = (NW > NODE_W) ? NW : NODE_W;

    // stores
    logic [CNT_W-1:0] r_cnt_mem  [DEPTH];
    logic [NW-1:0]    r_par_mem  [DEPTH];
    logic [NW-1:0]    r_code_mem [DEPTH];
    logic [CNT_W-1:0] r_cnt_q;
    logic [NW-1:0]    r_par_q, r_code_q;

    // store ports
    logic             w_cnt_we, w_par_we, w_code_we;
    logic [NW-1:0]    w_cnt_wa, w_par_wa, w_code_wa;
    logic [NW-1:0]    w_cnt_ra, w_par_ra, w_code_ra;
    logic [CNT_W-1:0] w_cnt_wd;
    logic [NW-1:0]    w_par_wd, w_code_wd;

    // registers
    logic              r_dir, n_dir;
    logic [NODE_W-1:0] r_ncount, n_ncount;
    logic [NW-1:0]     r_clr, n_clr;
    logic [NW-1:0]     r_lc, n_lc;
    logic              r_done, n_done;
    logic [NW-1:0]     r_p, n_p;
    logic [NW-1:0]     r_i, n_i;
    logic [NW-1:0]     r_v, n_v;
    logic              r_ld_ok, n_ld_ok;
    logic              r_rd_ok, n_rd_ok;

    // derived values
    logic [WW-1:0]    w_nc, w_n_full, w_vw, w_idx;
    logic [NW-1:0]    w_n, w_n2, w_len_ld, w_rlen, w_i1;
    logic [NW-1:0]    w_vin, w_lc_base, w_lc_next;
    logic [NW-1:0]    w_code_i, w_code_i1, w_leaf_v, w_chain_v;
    logic [CNT_W-1:0] w_dec_cnt;
    logic             w_ld_ok, w_rd_ok, w_chain, w_i1_le_l;

    // saturated node count and lengths
    assign w_nc     = WW'(r_ncount);
    assign w_n_full = (w_nc < WW'(MIN_NODES)) ? WW'(MIN_NODES) :
                      ((w_nc > WW'(MAX_NODES)) ? WW'(MAX_NODES) : w_nc);
    assign w_n      = w_n_full[NW-1:0];
    assign w_n2     = w_n - NW'(2);
    assign w_len_ld = r_dir ? w_n2 : (w_n - NW'(1));
    assign w_rlen   = r_dir ? (w_n - NW'(1)) : w_n2;

    // loaded value clamped into 1..n
    assign w_vw  = WW'(i_item.node_value);
    assign w_vin = ((w_vw == '0) || (w_vw > w_n_full)) ? w_n : w_vw[NW-1:0];

    // load position, a load after a finished job starts a new one
    assign w_lc_base = r_done ? '0 : r_lc;
    assign w_ld_ok   = (w_lc_base < w_len_ld);
    assign w_lc_next = w_lc_base + NW'(1);

    // read-back range check
    assign w_idx   = WW'(i_item.read_index);
    assign w_rd_ok = r_done && (w_idx != '0) && (w_idx <= WW'(w_rlen));

    // code positions past the end stand for the root
    assign w_i1      = r_i + NW'(1);
    assign w_i1_le_l = (w_i1 <= w_rlen);
    assign w_code_i  = (r_i <= w_n2) ? r_code_q : w_n;
    assign w_code_i1 = (w_i1 <= w_n2) ? r_code_q : w_n;
    assign w_leaf_v  = r_dir ? w_code_i : r_par_q;
    assign w_chain_v = r_dir ? w_code_i1 : r_par_q;

    // child count decrement, wraps below zero
    assign w_dec_cnt = r_cnt_q - CNT_W'(1);
    assign w_chain   = (w_dec_cnt == '0) && (r_v < r_p);

    // command decode
    always_comb begin
        w_cnt_we  = 1'b0;
        w_par_we  = 1'b0;
        w_code_we = 1'b0;
        w_cnt_wa  = r_v;
        w_par_wa  = r_p;
        w_code_wa = r_i;
        w_cnt_wd  = '0;
        w_par_wd  = '0;
        w_code_wd = '0;
        w_cnt_ra  = r_p;
        w_par_ra  = r_p;
        w_code_ra = r_i;
        n_dir     = r_dir;
        n_ncount  = r_ncount;
        n_clr     = r_clr;
        n_lc      = r_lc;
        n_done    = r_done;
        n_p       = r_p;
        n_i       = r_i;
        n_v       = r_v;
        n_ld_ok   = r_ld_ok;
        n_rd_ok   = r_rd_ok;
        case (i_cmd)
            CMD_CLR_CNT: begin
                w_cnt_we = 1'b1;
                w_cnt_wa = r_clr;
                n_clr    = r_clr + NW'(1);
            end
            CMD_LOAD: begin
                n_done   = 1'b0;
                n_v      = w_vin;
                n_ld_ok  = w_ld_ok;
                w_cnt_ra = w_vin;
                if (w_ld_ok) begin
                    n_lc = w_lc_next;
                    if (r_dir) begin
                        w_code_we = 1'b1;
                        w_code_wa = w_lc_next;
                        w_code_wd = w_vin;
                    end else begin
                        w_par_we = 1'b1;
                        w_par_wa = w_lc_next;
                        w_par_wd = w_vin;
                    end
                end else begin
                    n_lc = w_lc_base;
                end
            end
            CMD_LOAD_WR: begin
                w_cnt_we = r_ld_ok;
                w_cnt_wa = r_v;
                w_cnt_wd = r_cnt_q + CNT_W'(1);
                n_clr    = NW'(1);
            end
            CMD_READ: begin
                n_rd_ok   = w_rd_ok;
                w_par_ra  = w_rd_ok ? w_idx[NW-1:0] : '0;
                w_code_ra = w_rd_ok ? w_idx[NW-1:0] : '0;
            end
            CMD_CLR_RES: begin
                if (r_dir) begin
                    w_par_we = 1'b1;
                    w_par_wa = r_clr;
                end else begin
                    w_code_we = 1'b1;
                    w_code_wa = r_clr;
                end
                n_clr = r_clr + NW'(1);
                n_p   = NW'(1);
                n_i   = NW'(1);
            end
            CMD_FIND_RD: begin
                w_cnt_ra = r_p;
            end
            CMD_FIND_CK: begin
                if (r_cnt_q != '0) begin
                    n_p = r_p + NW'(1);
                end else begin
                    w_par_ra  = r_p;
                    w_code_ra = r_i;
                end
            end
            CMD_LEAF: begin
                n_v      = w_leaf_v;
                w_cnt_ra = w_leaf_v;
                if (r_dir) begin
                    w_par_we = 1'b1;
                    w_par_wa = r_p;
                    w_par_wd = w_leaf_v;
                end else begin
                    w_code_we = 1'b1;
                    w_code_wa = r_i;
                    w_code_wd = w_leaf_v;
                end
            end
            CMD_DEC: begin
                w_cnt_we = 1'b1;
                w_cnt_wa = r_v;
                w_cnt_wd = w_dec_cnt;
                if (w_chain) begin
                    w_par_ra  = r_v;
                    w_code_ra = w_i1;
                end else begin
                    n_i = w_i1;
                    n_p = r_p + NW'(1);
                end
            end
            CMD_CHAIN: begin
                if (r_dir) begin
                    w_par_we = 1'b1;
                    w_par_wa = r_v;
                    w_par_wd = w_chain_v;
                end else begin
                    w_code_we = w_i1_le_l;
                    w_code_wa = w_i1;
                    w_code_wd = w_chain_v;
                end
                n_i      = w_i1;
                n_v      = w_chain_v;
                w_cnt_ra = w_chain_v;
            end
            CMD_FINISH: begin
                n_done = 1'b1;
                n_clr  = NW'(1);
            end
            default: begin
            end
        endcase
        // register write starts a new job
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIRECTION:  n_dir    = i_cfg_data[0];
                CFG_NODE_COUNT: n_ncount = i_cfg_data;
                default: begin
                end
            endcase
            n_clr  = NW'(1);
            n_lc   = '0;
            n_done = 1'b0;
        end
    end

    // child count store
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) r_cnt_mem[w_cnt_wa] <= w_cnt_wd;
        r_cnt_q <= r_cnt_mem[w_cnt_ra];
    end

    // parent store
    always_ff @(posedge i_clk) begin
        if (w_par_we) r_par_mem[w_par_wa] <= w_par_wd;
        r_par_q <= r_par_mem[w_par_ra];
    end

    // code store
    always_ff @(posedge i_clk) begin
        if (w_code_we) r_code_mem[w_code_wa] <= w_code_wd;
        r_code_q <= r_code_mem[w_code_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= 1'b0;
            r_ncount <= NCOUNT_RESET;
            r_clr    <= NW'(1);
            r_lc     <= '0;
            r_done   <= 1'b0;
            r_p      <= NW'(1);
            r_i      <= NW'(1);
            r_ld_ok  <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else begin
            r_dir    <= n_dir;
            r_ncount <= n_ncount;
            r_clr    <= n_clr;
            r_lc     <= n_lc;
            r_done   <= n_done;
            r_p      <= n_p;
            r_i      <= n_i;
            r_ld_ok  <= n_ld_ok;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // current node value
    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    // status for the controller
    assign o_status.clr_cnt_last = (r_clr == w_n);
    assign o_status.clr_res_last = (r_clr == w_rlen);
    assign o_status.load_last    = r_ld_ok && (r_lc == w_len_ld);
    assign o_status.p_ge_n       = (r_p >= w_n);
    assign o_status.cnt_nz       = (r_cnt_q != '0);
    assign o_status.chain        = w_chain;
    assign o_status.i1_le_l      = w_i1_le_l;

    // read-back result
    assign o_result.result_value = r_rd_ok ? NODE_W'(r_dir ? r_par_q : r_code_q) : '0;
    assign o_result.result_valid = r_rd_ok;

endmodule
